@@ hdl/bmt3_pkg.sv @@
package bmt3_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 32;
    localparam int IWIDTH_W = 12;
    localparam int MARK_W   = 8;
    localparam int POS_W    = 11;
    localparam int OUT_W    = 32;

    localparam logic [IWIDTH_W-1:0] RST_IMAGE_WIDTH = 12'd640;
    localparam logic [SAMPLE_W-1:0] RST_THRESHOLD   = 32'd10000;

    localparam logic [MARK_W-1:0] MARK_SET   = 8'd255;
    localparam logic [MARK_W-1:0] MARK_CLEAR = 8'd0;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH = 1'b0,
        REG_THRESHOLD   = 1'b1
    } reg_index_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    function automatic sample_t max_s(input sample_t a, input sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ hdl/block_max_threshold_3x3_unit.sv @@
// Channel   Dir  Handshake          Contents
// -------   ---  ---------          --------
// s_*       in   s_tvalid/s_tready  tdata: sample; tuser: first_of_frame
// m_*       out  m_tvalid/m_tready  tdata: mark, centre_row, centre_col
// wr_*      in   wr_en              register index and data, no read-back
//
// One request per cycle sustained while the output drains; the request that
// completes a tile passes the input register, then the output register.
// The per-group maxima sit in a single-port-write memory with a registered
// read issued at accept time; a same-cycle write to the same group is bypassed.
// rst_n clears counters, the running maximum and valid flags; the group
// memory needs no clearing. A stalled output backs up through s_tready.
module block_max_threshold_3x3_unit #(
    parameter int MAX_WIDTH  = bmt3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmt3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmt3_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  logic                          s_tuser,   // [0] first_of_frame
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmt3_pkg::OUT_W-1:0]    m_tdata,   // [7:0] mark, [18:8] centre_row,
                                                     // [29:19] centre_col, [31:30] zero
    input  logic                          wr_en,
    input  bmt3_pkg::reg_index_t          wr_index,
    input  logic [bmt3_pkg::CFG_W-1:0]    wr_data
);
    import bmt3_pkg::*;

    localparam int GROUPS = (MAX_WIDTH + 2) / 3;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    // configuration
    logic [IWIDTH_W-1:0] image_width_reg;
    sample_t             threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= RST_IMAGE_WIDTH;
            threshold_reg   <= sample_t'(RST_THRESHOLD);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH: image_width_reg <= wr_data[IWIDTH_W-1:0];
                REG_THRESHOLD:   threshold_reg   <= sample_t'(wr_data);
                default:         ;
            endcase
        end
    end

    // effective width, clamped to 1..MAX_WIDTH
    logic [31:0]   width32;
    logic [31:0]   width_clamp;
    logic [CW-1:0] width;

    assign width32     = {{(32-IWIDTH_W){1'b0}}, image_width_reg};
    assign width_clamp = (width32 == 32'd0) ? 32'd1 :
                         (width32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : width32;
    assign width       = width_clamp[CW-1:0];

    // position counters
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [1:0]    phase_reg;
    logic [1:0]    sub_reg;
    logic [GW-1:0] grp_reg;

    // stage B (input register)
    logic          b_valid_reg;
    sample_t       b_sample_reg;
    logic [1:0]    b_phase_reg;
    logic          b_sub0_reg;
    logic          b_emit_reg;
    logic [POS_W-1:0] b_row_reg;
    logic [POS_W-1:0] b_col_reg;
    logic [GW-1:0] b_grp_reg;
    sample_t       mem_rd_reg;
    logic          byp_reg;
    sample_t       byp_data_reg;
    sample_t       acc_reg;

    // output register
    logic             m_valid_reg;
    logic [MARK_W-1:0] m_mark_reg;
    logic [POS_W-1:0] m_row_reg;
    logic [POS_W-1:0] m_col_reg;

    sample_t grp_mem [GROUPS];

    logic b_adv;
    logic s_fire;
    logic b_write;
    sample_t acc_next;

    assign b_adv    = b_valid_reg && (!b_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_adv;
    assign s_fire   = s_tvalid && s_tready;
    assign b_write  = b_adv && (b_phase_reg != 2'd2);

    // ---- position bookkeeping for the incoming request ----
    logic [RW-1:0] r0, r1, r2;
    logic [CW-1:0] c0, c1, c2;
    logic [1:0]    p0, p1, p2;
    logic [1:0]    s0, s1, s2;
    logic [GW-1:0] g0, g1, g2;
    logic          ignore;
    logic          emit;
    logic [31:0]   crow32;
    logic [31:0]   ccol32;

    always_comb
    begin
        r0 = s_tuser ? '0 : row_reg;
        c0 = s_tuser ? '0 : col_reg;
        p0 = s_tuser ? '0 : phase_reg;
        s0 = s_tuser ? '0 : sub_reg;
        g0 = s_tuser ? '0 : grp_reg;

        // width may have shrunk since the last request
        r1 = r0;
        c1 = c0;
        p1 = p0;
        s1 = s0;
        g1 = g0;
        if (c0 >= width)
        begin
            c1 = '0;
            s1 = '0;
            g1 = '0;
            r1 = (32'(r0) < 32'(MAX_HEIGHT)) ? r0 + RW'(1) : r0;
            p1 = (p0 >= 2'd2) ? 2'd0 : p0 + 2'd1;
        end
        ignore = (32'(r1) >= 32'(MAX_HEIGHT));

        c2 = c1 + CW'(1);
        s2 = (s1 == 2'd2) ? 2'd0 : s1 + 2'd1;
        g2 = (s1 == 2'd2) ? g1 + GW'(1) : g1;
        r2 = r1;
        p2 = p1;
        emit = (p1 == 2'd2) && ((s1 == 2'd2) || ((s1 == 2'd1) && (c2 == width)));
        if (c2 >= width)
        begin
            c2 = '0;
            s2 = '0;
            g2 = '0;
            r2 = (32'(r1) < 32'(MAX_HEIGHT)) ? r1 + RW'(1) : r1;
            p2 = (p1 >= 2'd2) ? 2'd0 : p1 + 2'd1;
        end

        crow32 = 32'(r1) - 32'd1;
        ccol32 = 32'(c1) - 32'(s1) + 32'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            sub_reg   <= '0;
            grp_reg   <= '0;
        end
        else if (s_fire)
        begin
            row_reg   <= ignore ? r1 : r2;
            col_reg   <= ignore ? c1 : c2;
            phase_reg <= ignore ? p1 : p2;
            sub_reg   <= ignore ? s1 : s2;
            grp_reg   <= ignore ? g1 : g2;
        end
    end

    // ---- stage B ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            b_valid_reg <= !ignore;
        end
        else if (b_adv)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            b_sample_reg <= sample_t'(s_tdata);
            b_phase_reg  <= p1;
            b_sub0_reg   <= (s1 == 2'd0);
            b_emit_reg   <= emit;
            b_row_reg    <= crow32[POS_W-1:0];
            b_col_reg    <= ccol32[POS_W-1:0];
            b_grp_reg    <= g1;
            // the previous request may write this group at this same edge
            byp_reg      <= b_write && (b_grp_reg == g1);
            byp_data_reg <= acc_next;
        end
    end

    // group maxima memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (b_write)
        begin
            grp_mem[b_grp_reg] <= acc_next;
        end
        if (s_fire)
        begin
            mem_rd_reg <= grp_mem[g1];
        end
    end

    sample_t grp_rd;
    sample_t acc_base;

    always_comb
    begin
        grp_rd   = byp_reg ? byp_data_reg : mem_rd_reg;
        acc_base = b_sub0_reg ? grp_rd : acc_reg;
        if (b_sub0_reg && (b_phase_reg == 2'd0))
        begin
            acc_next = b_sample_reg;
        end
        else
        begin
            acc_next = max_s(acc_base, b_sample_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (b_adv)
        begin
            acc_reg <= acc_next;
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (b_adv && b_emit_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && b_emit_reg)
        begin
            m_mark_reg <= (acc_next > threshold_reg) ? MARK_SET : MARK_CLEAR;
            m_row_reg  <= b_row_reg;
            m_col_reg  <= b_col_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W - MARK_W - 2*POS_W){1'b0}}, m_col_reg, m_row_reg, m_mark_reg};

    // ---- assertions ----
    a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> ((m_mark_reg == MARK_SET) || (m_mark_reg == MARK_CLEAR)))
        else $error("mark is neither set nor clear");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_emit_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while a result is blocked");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 2'd3) && (sub_reg != 2'd3))
        else $error("band phase or column phase out of range");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tuser) |=> (col_reg <= CW'(1)) && (row_reg <= RW'(1)))
        else $error("frame start did not restart the counters");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_emit_reg) |-> (b_phase_reg == 2'd2) && !b_write)
        else $error("result from a row outside the third of a band");

endmodule

@@ tb/tb_block_max_threshold_3x3_unit.sv @@
module tb_block_max_threshold_3x3_unit;
    import bmt3_pkg::*;

    localparam int GROUPS           = (DEF_MAX_WIDTH + 2) / 3;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 8;
    localparam int RANDOM_PIXELS    = 900;
    localparam int MAX_RANDOM_WIDTH = 40;

    localparam sample_t S_MIN = 32'h8000_0000;
    localparam sample_t S_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } tile_mark_t;

    // Predicts tile marks from accepted pixels and checks them in order.
    class tile_mark_scoreboard;
        logic [IWIDTH_W-1:0] width_reg;
        sample_t             threshold;
        sample_t             group_max [GROUPS];
        sample_t             tile_max;
        int unsigned         row_pos;
        int unsigned         col_pos;
        int unsigned         band_row;
        tile_mark_t          expected_marks [$];
        int                  errors;
        int                  checked;

        function new();
            width_reg = RST_IMAGE_WIDTH;
            threshold = RST_THRESHOLD;
            foreach (group_max[i])
                group_max[i] = '0;
            tile_max = '0;
            row_pos  = 0;
            col_pos  = 0;
            band_row = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(reg_index_t which, logic [CFG_W-1:0] data);
            case (which)
                REG_IMAGE_WIDTH: width_reg = data[IWIDTH_W-1:0];
                REG_THRESHOLD:   threshold = sample_t'(data);
                default:         ;
            endcase
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = width_reg;
            if (w == 0)
                w = 1;
            if (w > DEF_MAX_WIDTH)
                w = DEF_MAX_WIDTH;
            return w;
        endfunction

        function void advance_row();
            col_pos = 0;
            if (row_pos < DEF_MAX_HEIGHT)
                row_pos++;
            band_row = (band_row >= 2) ? 0 : band_row + 1;
        endfunction

        function int pending();
            return expected_marks.size();
        endfunction

        function void take_pixel(sample_t value, logic frame_start);
            int unsigned w;
            int unsigned c;
            int unsigned g;
            int unsigned sub;
            tile_mark_t  r;
            w = active_width();
            if (frame_start)
            begin
                row_pos  = 0;
                col_pos  = 0;
                band_row = 0;
            end
            // width may have shrunk under a partly sent row
            if (col_pos >= w)
                advance_row();
            if (row_pos >= DEF_MAX_HEIGHT)
                return;
            c   = col_pos;
            g   = c / 3;
            sub = c % 3;
            if (band_row == 0)
                group_max[g] = (sub == 0 || value > group_max[g]) ? value : group_max[g];
            else if (band_row == 1)
                group_max[g] = (value > group_max[g]) ? value : group_max[g];
            else
            begin
                if (sub == 0)
                    tile_max = (value > group_max[g]) ? value : group_max[g];
                else if (value > tile_max)
                    tile_max = value;
                // tile closes on its third column, or on its second at row end
                if (sub == 2 || (sub == 1 && c + 1 == w))
                begin
                    r.mark = (tile_max > threshold) ? MARK_SET : MARK_CLEAR;
                    r.row  = POS_W'(row_pos - 1);
                    r.col  = POS_W'(g * 3 + 1);
                    expected_marks.push_back(r);
                end
            end
            col_pos = c + 1;
            if (col_pos >= w)
                advance_row();
        endfunction

        function void check_mark(logic [OUT_W-1:0] data);
            tile_mark_t want;
            if (expected_marks.size() == 0)
            begin
                $display("%0t: result %h with none expected", $time, data);
                errors++;
                return;
            end
            want = expected_marks.pop_front();
            checked++;
            if (data[MARK_W-1:0] != want.mark)
            begin
                $display("%0t: mark expected %0d actual %0d", $time, want.mark,
                         data[MARK_W-1:0]);
                errors++;
            end
            if (data[MARK_W +: POS_W] != want.row)
            begin
                $display("%0t: centre_row expected %0d actual %0d", $time, want.row,
                         data[MARK_W +: POS_W]);
                errors++;
            end
            if (data[MARK_W+POS_W +: POS_W] != want.col)
            begin
                $display("%0t: centre_col expected %0d actual %0d", $time, want.col,
                         data[MARK_W+POS_W +: POS_W]);
                errors++;
            end
            if (data[OUT_W-1:MARK_W+2*POS_W] != '0)
            begin
                $display("%0t: tdata pad expected 0 actual %h", $time,
                         data[OUT_W-1:MARK_W+2*POS_W]);
                errors++;
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                wr_en    = 1'b0;
    reg_index_t          wr_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]    wr_data  = '0;

    tile_mark_scoreboard sb;

    int burst_left  = 0;
    int gap_max     = 0;
    int pixels_sent = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int mode_timer  = 0;

    block_max_threshold_3x3_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #6 clk = ~clk;

    // receiver: free-running stall pattern, mode redrawn when its timer runs out
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (stall_mode != 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, (stall_mode == 1) ? 3 : 24);
        end
        if (mode_timer == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = $urandom_range(50, 400);
        end
        else
            mode_timer--;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.take_pixel(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_mark(m_tdata);
    end

    function automatic sample_t pick_sample(input bit quiet);
        sample_t v;
        // quiet: mostly at or just under the threshold so clear marks show up
        if (quiet && $urandom_range(0, 15) != 0)
        begin
            v = sb.threshold - sample_t'($urandom_range(0, 3));
            return (v > sb.threshold) ? sb.threshold : v;
        end
        case ($urandom_range(0, 9))
            0:       return S_MIN;
            1:       return S_MAX;
            2, 3, 4: return sb.threshold + sample_t'($urandom_range(0, 4)) - sample_t'(2);
            5, 6:    return sample_t'($urandom_range(0, 40000)) - sample_t'(20000);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width_word();
        logic [CFG_W-1:0] word;
        word = $urandom;
        case ($urandom_range(0, 7))
            0:          word[IWIDTH_W-1:0] = '0;
            1, 2, 3:    word[IWIDTH_W-1:0] = IWIDTH_W'($urandom_range(1, 7));
            default:    word[IWIDTH_W-1:0] = IWIDTH_W'($urandom_range(8, MAX_RANDOM_WIDTH));
        endcase
        return word;
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold_word();
        case ($urandom_range(0, 7))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return RST_THRESHOLD;
            4, 5:    return $urandom;
            default: return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
        endcase
    endfunction

    task automatic configure(input logic [CFG_W-1:0] width_word,
                             input logic [CFG_W-1:0] threshold_word);
        wr_en    <= 1'b1;
        wr_index <= REG_IMAGE_WIDTH;
        wr_data  <= width_word;
        sb.set_reg(REG_IMAGE_WIDTH, width_word);
        @(posedge clk);
        wr_index <= REG_THRESHOLD;
        wr_data  <= threshold_word;
        sb.set_reg(REG_THRESHOLD, threshold_word);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic push_pixel(input sample_t value, input logic frame_start);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= frame_start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        pixels_sent++;
    endtask

    task automatic run_frame(input int rows, input int extra, input bit start,
                             input bit quiet, input bit noisy);
        int   total;
        logic sof;
        total = rows * sb.active_width() + extra;
        for (int i = 0; i < total; i++)
        begin
            sof = (i == 0 && start) || (noisy && $urandom_range(0, 199) == 0);
            push_pixel(pick_sample(quiet), sof);
        end
    endtask

    // idle the block: no request pending, all marks in, pipeline flushed
    task automatic settle();
        s_tvalid <= 1'b0;
        // let the monitor take the last accepted request first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sample_t seed_frame [15];
        int      base_pixels;
        seed_frame = '{
            -5,    S_MIN, 10000, 10001, 0,
            9999,  -1,    0,     S_MIN, 42,
            10000, 3,     S_MIN, S_MAX, -7
        };
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width 5: first tile peaks exactly at the threshold, second has two columns
        gap_max = 2;
        configure(32'd5, RST_THRESHOLD);
        for (int i = 0; i < 15; i++)
            push_pixel(seed_frame[i], i == 0);
        push_pixel(S_MAX, 1'b0);
        push_pixel(S_MIN, 1'b1);
        settle();

        // width 0 acts as 1: no centre column, nothing comes out
        configure(32'd0, S_MIN);
        for (int i = 0; i < 4; i++)
            push_pixel(S_MAX, i == 0);
        settle();

        // all-ones word clamps to full width; a partial first row writes
        // every group entry that the random widths below can reach
        gap_max = 3;
        configure('1, '0);
        run_frame(0, MAX_RANDOM_WIDTH, 1'b1, 1'b1, 1'b0);

        base_pixels = pixels_sent;
        while (pixels_sent - base_pixels < RANDOM_PIXELS)
        begin
            settle();
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            configure(pick_width_word(), pick_threshold_word());
            run_frame($urandom_range(1, 7), $urandom_range(0, 2),
                      $urandom_range(0, 6) != 0, $urandom_range(0, 2) == 0, 1'b1);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bmt3_pkg.sv
hdl/block_max_threshold_3x3_unit.sv
tb/tb_block_max_threshold_3x3_unit.sv
